FILE: rtl/core/lbs_pkg.sv
// package: shared types and constants for linear blend skinning
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;
    localparam int MaxBones  = 64;
    localparam int MatWords  = 12;
    localparam int MemDepth  = MaxBones * MatWords;
    localparam int MemAw     = $clog2(MemDepth);
    localparam int BoneW     = 6;
    localparam int AccW      = 48;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONTRIB = 1'b1;

    localparam logic [1:0] REG_BLEND_EN = 2'd0;
    localparam logic [1:0] REG_BLEND_WT = 2'd1;

    typedef struct packed {
        logic              op;
        logic [BoneW-1:0]  bone;
        logic              matrix_set;
        logic [3:0]        element;
        logic signed [31:0] value;
        logic [15:0]       weight;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_z;
        logic              last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic              saturated;
    } t_out;

    // memory write and read request from the sequencer to the pose store
    typedef struct packed {
        logic              we;
        logic              set;
        logic [MemAw-1:0]  waddr;
        logic [31:0]       wdata;
        logic [MemAw-1:0]  raddr;
    } t_mem_req;
endpackage
`default_nettype wire

FILE: rtl/core/lbs_if.sv
// interface: valid/ready channel carrying a payload
`timescale 1ns / 1ps
`default_nettype none
interface lbs_in_if;
    logic         valid;
    logic         ready;
    lbs_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbs_out_if;
    logic          valid;
    logic          ready;
    lbs_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lbs_pose_mem.sv
// pose store: current and previous bone matrix tables, registered read
`timescale 1ns / 1ps
`default_nettype none
module lbs_pose_mem (
    input  wire logic               i_clk,
    input  wire lbs_pkg::t_mem_req  i_req,
    output logic [31:0]             o_cur,
    output logic [31:0]             o_prev
);
    logic [31:0] r_cur_mem  [lbs_pkg::MemDepth];
    logic [31:0] r_prev_mem [lbs_pkg::MemDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.we && !i_req.set) begin
            r_cur_mem[i_req.waddr] <= i_req.wdata;
        end
        o_cur <= r_cur_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.set) begin
            r_prev_mem[i_req.waddr] <= i_req.wdata;
        end
        o_prev <= r_prev_mem[i_req.raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/lbs_engine.sv
// sequencer: reads matrix elements, blends, multiplies and accumulates
`timescale 1ns / 1ps
`default_nettype none
module lbs_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_blend_en,
    input  wire logic [16:0]   i_blend_wt,
    lbs_in_if.sink             s_in,
    lbs_out_if.source          m_out,
    output lbs_pkg::t_mem_req  o_req,
    input  wire logic [31:0]   i_cur,
    input  wire logic [31:0]   i_prev
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_WGT   = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

    logic [2:0]  r_state, n_state;
    lbs_pkg::t_in r_item;
    logic [15:0] r_w;
    logic [1:0]  r_row;
    logic [1:0]  r_col;
    logic [lbs_pkg::MemAw-1:0] r_base;
    logic signed [31:0] r_m;
    logic signed [63:0] r_prod;
    logic signed [49:0] r_s;
    logic signed [49:0] r_t;
    logic signed [47:0] r_acc [3];
    logic        r_ovalid;
    lbs_pkg::t_out r_odata;

    logic signed [49:0] s_blend;
    logic signed [31:0] s_off;
    logic signed [49:0] s_wgt;
    logic signed [49:0] s_sum;
    logic signed [47:0] s_new;
    logic [3:0]  s_elem;
    logic        s_take;
    logic        s_sat;

    assign s_take = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;

    assign s_elem = {r_row, r_col};
    always_comb begin
        o_req.we    = s_take && (s_in.data.op == lbs_pkg::OP_WRITE)
                      && (s_in.data.element < 4'(lbs_pkg::MatWords));
        o_req.set   = s_in.data.matrix_set;
        o_req.waddr = lbs_pkg::MemAw'(s_in.data.bone * lbs_pkg::MatWords)
                      + lbs_pkg::MemAw'(s_in.data.element);
        o_req.wdata = s_in.data.value;
        o_req.raddr = r_base + lbs_pkg::MemAw'(s_elem);
    end

    always_comb begin
        s_blend = ((50'(signed'(i_prev)) * 50'(signed'({1'b0, 17'(18'd65536
                  - {1'b0, i_blend_wt})})))
                  + (50'(signed'(i_cur)) * 50'(signed'({1'b0, i_blend_wt})))) >>> 16;
        case (r_col)
            2'd0:    s_off = r_item.off_x;
            2'd1:    s_off = r_item.off_y;
            default: s_off = r_item.off_z;
        endcase
        s_wgt = (r_s >>> 15) * 50'(signed'({1'b0, r_w}))
              + signed'(50'(((50'(r_s[14:0]) * 50'(r_w)) >> 15)));
        s_sum = 50'(r_acc[r_row]) + r_t;
        if (s_sum > 50'(AccMax)) begin
            s_new = AccMax;
        end else if (s_sum < 50'(AccMin)) begin
            s_new = AccMin;
        end else begin
            s_new = s_sum[47:0];
        end
        s_sat = 1'b0;
    end

    function automatic logic signed [31:0] clip32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic clipped(input logic signed [47:0] v);
        return (v > 48'sh0000_7FFF_FFFF) || (v < -48'sh0000_8000_0000);
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_take && s_in.data.op == lbs_pkg::OP_CONTRIB) begin
                    if (s_in.data.weight != 16'd0
                        && 32'(s_in.data.bone) < lbs_pkg::MaxBones) begin
                        n_state = ST_READ;
                    end else if (s_in.data.last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_READ:  n_state = ST_BLEND;
            ST_BLEND: n_state = (r_col == 2'd3) ? ST_ADD : ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = (r_col == 2'd2) ? ST_WGT : ST_READ;
            ST_WGT:   n_state = ST_ACC;
            ST_ACC: begin
                if (r_row != 2'd2) begin
                    n_state = ST_READ;
                end else if (r_item.last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT:  n_state = (r_ovalid && !m_out.ready) ? ST_EMIT : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_row    <= '0;
            r_col    <= 2'd3;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && !(r_ovalid && !m_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_take) begin
                        r_item <= s_in.data;
                        r_w    <= (s_in.data.weight > 16'd32768) ? 16'd32768
                                  : s_in.data.weight;
                        r_base <= lbs_pkg::MemAw'(s_in.data.bone * lbs_pkg::MatWords);
                        r_row  <= '0;
                        r_col  <= 2'd3;
                    end
                end
                ST_BLEND: begin
                    r_m <= i_blend_en ? signed'(s_blend[31:0]) : signed'(i_cur);
                    if (r_col == 2'd3) begin
                        r_s <= 50'(i_blend_en ? signed'(s_blend[31:0]) : signed'(i_cur));
                    end
                end
                ST_MUL: r_prod <= 64'(r_m) * 64'(s_off);
                ST_ADD: begin
                    if (r_col != 2'd3) begin
                        r_s <= r_s + 50'(r_prod >>> 16);
                    end
                    r_col <= r_col + 2'd1;
                end
                ST_WGT: r_t <= s_wgt;
                ST_ACC: begin
                    r_acc[r_row] <= s_new;
                    r_row <= r_row + 2'd1;
                    r_col <= 2'd3;
                end
                ST_EMIT: begin
                    if (!(r_ovalid && !m_out.ready)) begin
                        r_odata.pos_x <= clip32(r_acc[0]);
                        r_odata.pos_y <= clip32(r_acc[1]);
                        r_odata.pos_z <= clip32(r_acc[2]);
                        r_odata.saturated <= s_sat | clipped(r_acc[0])
                                             | clipped(r_acc[1]) | clipped(r_acc[2]);
                        r_acc[0] <= '0;
                        r_acc[1] <= '0;
                        r_acc[2] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/linear_blend_skinning_top.sv
// top level: linear blend skinning with apb configuration
`timescale 1ns / 1ps
`default_nettype none
// A matrix element write is accepted while idle. A nonzero-weight contribution
// runs over the one pose-store read port: per row, the translation is read and
// blended, then each of the three columns is read, blended, multiplied and
// added, then a weight multiply and an accumulate follow; the next transfer is
// taken only after the last row. A final contribution then presents the
// position, held back while an earlier position is still waiting at the output.
// A zero-weight contribution is skipped, though a final one still presents the
// position. Pose tables are not cleared at reset.
module linear_blend_skinning_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    lbs_in_if.sink           s_in,
    lbs_out_if.source        m_out
);
    logic        r_blend_en;
    logic [16:0] r_blend_wt;
    lbs_pkg::t_mem_req s_req;
    logic [31:0] s_cur, s_prev;
    logic        s_wr;

    assign pready = 1'b1;
    assign s_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_en <= 1'b0;
            r_blend_wt <= '0;
        end else if (s_wr) begin
            case (paddr[2:2] == 1'b0 ? lbs_pkg::REG_BLEND_EN : lbs_pkg::REG_BLEND_WT)
                lbs_pkg::REG_BLEND_EN: r_blend_en <= (paddr[1:0] == 2'd0) ? pwdata[0]
                                                     : r_blend_en;
                lbs_pkg::REG_BLEND_WT: r_blend_wt <= (pwdata[16:0] > 17'd65536)
                                                     ? 17'd65536 : pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {31'd0, r_blend_en};
            default: prdata = {15'd0, r_blend_wt};
        endcase
    end

    lbs_pose_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (s_req),
        .o_cur  (s_cur),
        .o_prev (s_prev)
    );

    lbs_engine u_eng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blend_en (r_blend_en),
        .i_blend_wt (r_blend_wt),
        .s_in       (s_in),
        .m_out      (m_out),
        .o_req      (s_req),
        .i_cur      (s_cur),
        .i_prev     (s_prev)
    );

    a_wt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blend_wt <= 17'd65536) else $error("blend weight out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result dropped");
    a_pready: assert property (@(posedge i_clk) pready) else $error("apb not ready");
endmodule
`default_nettype wire
